/* rtl/dtoa_pkg.sv */
// Package for the date-time offset adder: constants, stage records and the month length table.
package dtoa_pkg;

    // Calendar and clock constants
    localparam int unsigned OffFracBits   = 3;
    localparam int unsigned MinuteWrap    = 6;
    localparam int unsigned HoursPerDay   = 24;
    localparam int unsigned MonthsPerYear = 12;

    // Payload widths
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 24;

    // Stage 1: minutes settled, raw hour sum, calendar month normalised
    typedef struct packed {
        logic [2:0]        mins;
        logic signed [10:0] hsum;
        logic              hr0_lt24;
        logic [4:0]        day0;
        logic [3:0]        month;
        logic [6:0]        year;
    } s1_t;

    // Stage 2: hour reduced, day moved by whole days
    typedef struct packed {
        logic [2:0]        mins;
        logic [4:0]        hour;
        logic signed [6:0] day;
        logic              hr0_lt24;
        logic              day0_pos;
        logic [3:0]        month;
        logic [6:0]        year;
    } s2_t;

    // Stage 3: final result
    typedef struct packed {
        logic [2:0] mins;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } s3_t;

    // Days in a month; month zero and unknown codes count as 31 days
    function automatic logic [4:0] month_length(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] len;
        case (month)
            4'd2:                      len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/date_time_offset_adder_top.sv */
// Top level of the date-time offset adder: three-stage pipeline behind a stream interface.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------------
//  s       | in  | s_tvalid/s_tready  | s_tdata: minute_tens, hour, day_of_month,
//          |     |                    |          month_number, year_offset, time_offset
//  m       | out | m_tvalid/m_tready  | m_tdata: new_minute_tens, new_hour, new_day,
//          |     |                    |          new_month, new_year
//
// A request is taken every cycle unless a stall at m backs up into stage 1.
// Stage 1 splits the offset and settles minutes, stage 2 reduces hours by a reciprocal
// multiply by 1/24, stage 3 applies midnight and the single day carry or borrow.
// Reset clears the stage valid bits only. A stall at m holds stage 3 and the full stages
// in line behind it; empty ones fill, so bubbles are squeezed out while a result waits.
module date_time_offset_adder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] minute_tens, [7:3] hour, [12:8] day_of_month, [16:13] month_number,
    // [23:17] year_offset, [36:24] time_offset, [39:37] zero
    input  logic [dtoa_pkg::InDataW-1:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] new_minute_tens, [7:3] new_hour, [12:8] new_day, [16:13] new_month,
    // [23:17] new_year
    output logic [dtoa_pkg::OutDataW-1:0] m_tdata
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    dtoa_pkg::s1_t s1_reg, s1_next;
    dtoa_pkg::s2_t s2_reg, s2_next;
    dtoa_pkg::s3_t s3_reg, s3_next;

    // Stage enables: a stage loads when empty or when its content moves on
    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // Stage 1: split the offset, settle minutes, normalise month above twelve
    logic [2:0]         in_mins;
    logic [4:0]         in_hour;
    logic [4:0]         in_day;
    logic [3:0]         in_month;
    logic [6:0]         in_year;
    logic signed [12:0] in_off;
    logic signed [12:0] off_q;
    logic signed [12:0] off_r;
    logic signed [4:0]  mins_sum;
    logic signed [10:0] h_sum;

    always_comb
    begin
        in_mins  = s_tdata[2:0];
        in_hour  = s_tdata[7:3];
        in_day   = s_tdata[12:8];
        in_month = s_tdata[16:13];
        in_year  = s_tdata[23:17];
        in_off   = $signed(s_tdata[36:24]);
        off_q    = in_off / 13'sd8;
        off_r    = in_off % 13'sd8;
        mins_sum = $signed({2'b00, in_mins}) + off_r[4:0];
        h_sum    = $signed({6'b0, in_hour}) + off_q[10:0];
        s1_next.mins = mins_sum[2:0];
        if (mins_sum >= $signed(5'(dtoa_pkg::MinuteWrap)))
        begin
            s1_next.mins = 3'(mins_sum - 5'(dtoa_pkg::MinuteWrap));
            h_sum        = h_sum + 11'sd1;
        end
        else if (mins_sum < 5'sd0)
        begin
            s1_next.mins = 3'(mins_sum + 5'(dtoa_pkg::MinuteWrap));
            h_sum        = h_sum - 11'sd1;
        end
        s1_next.hsum     = h_sum;
        s1_next.hr0_lt24 = (in_hour < 5'(dtoa_pkg::HoursPerDay));
        s1_next.day0     = in_day;
        s1_next.month    = in_month;
        s1_next.year     = in_year;
        if (in_month > 4'(dtoa_pkg::MonthsPerYear))
        begin
            s1_next.month = 4'd1;
            s1_next.year  = in_year + 7'd1;
        end
    end

    // Stage 2: reduce hours into range, moving the day by whole days
    logic [9:0]  red_x;
    logic [6:0]  red_y;
    logic [14:0] k_prod;
    logic [4:0]  k_days;
    logic [9:0]  k_hours;
    logic signed [10:0] h_red;
    logic        h_above, h_below;

    always_comb
    begin
        h_above = (s1_reg.hsum > 11'sd24);
        h_below = (s1_reg.hsum < 11'sd0);
        if (h_above)
            red_x = 10'(s1_reg.hsum - 11'sd1);
        else
            red_x = 10'(11'sd23 - s1_reg.hsum);
        // floor(x/24) = floor(floor(x/8)/3), divide by 3 as multiply by 171/512
        red_y   = red_x[9:3];
        k_prod  = 15'(red_y) * 15'd171;
        k_days  = (h_above || h_below) ? k_prod[13:9] : 5'd0;
        k_hours = {1'b0, k_days, 4'b0} + {2'b0, k_days, 3'b0};
        if (h_below)
        begin
            h_red       = s1_reg.hsum + $signed({1'b0, k_hours});
            s2_next.day = $signed({2'b00, s1_reg.day0}) - $signed({2'b00, k_days});
        end
        else
        begin
            h_red       = s1_reg.hsum - $signed({1'b0, k_hours});
            s2_next.day = $signed({2'b00, s1_reg.day0}) + $signed({2'b00, k_days});
        end
        s2_next.hour     = h_red[4:0];
        s2_next.mins     = s1_reg.mins;
        s2_next.hr0_lt24 = s1_reg.hr0_lt24;
        s2_next.day0_pos = (s1_reg.day0 != 5'd0);
        s2_next.month    = s1_reg.month;
        s2_next.year     = s1_reg.year;
    end

    // Stage 3: midnight, then one day carry or borrow into month and year
    logic signed [6:0] d_mid;
    logic signed [6:0] d_fin;
    logic [4:0]        dim;
    logic [3:0]        m_fin;
    logic [6:0]        y_fin;

    always_comb
    begin
        d_mid        = s2_reg.day;
        s3_next.hour = s2_reg.hour;
        if (s2_reg.hour == 5'(dtoa_pkg::HoursPerDay))
        begin
            s3_next.hour = 5'd0;
            if (s2_reg.hr0_lt24)
                d_mid = s2_reg.day + 7'sd1;
        end
        dim   = dtoa_pkg::month_length(s2_reg.month, s2_reg.year);
        m_fin = s2_reg.month;
        y_fin = s2_reg.year;
        d_fin = d_mid;
        if (d_mid > $signed({2'b00, dim}))
        begin
            d_fin = d_mid - $signed({2'b00, dim});
            if (s2_reg.month >= 4'(dtoa_pkg::MonthsPerYear))
            begin
                m_fin = 4'd1;
                y_fin = s2_reg.year + 7'd1;
            end
            else
                m_fin = s2_reg.month + 4'd1;
        end
        else if (s2_reg.day0_pos && d_mid < 7'sd1)
        begin
            if (s2_reg.month <= 4'd1)
            begin
                m_fin = 4'(dtoa_pkg::MonthsPerYear);
                y_fin = s2_reg.year - 7'd1;
            end
            else
                m_fin = s2_reg.month - 4'd1;
            d_fin = d_mid + $signed({2'b00, dtoa_pkg::month_length(m_fin, y_fin)});
        end
        s3_next.mins  = s2_reg.mins;
        s3_next.day   = d_fin[4:0];
        s3_next.month = m_fin;
        s3_next.year  = y_fin;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // Advance payload; hold while stalled
    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
        if (en3)
            s3_reg <= s3_next;
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {s3_reg.year, s3_reg.month, s3_reg.day, s3_reg.hour, s3_reg.mins};

endmodule
